// ----- hw/rtl/fuzzy_membership_eval_unit_assert.svh -----
// assertion macros shared by the fuzzy membership evaluator checkers
`ifndef FUZZY_MEMBERSHIP_EVAL_UNIT_ASSERT_SVH
`define FUZZY_MEMBERSHIP_EVAL_UNIT_ASSERT_SVH

// same-cycle implication, muted while reset is asserted
`define FME_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fme assertion failed");

// next-cycle implication, muted while reset is asserted
`define FME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fme assertion failed");

`endif

// ----- hw/rtl/fme_pkg.sv -----
// shared constants, types and register map of the fuzzy membership evaluator
package fme_pkg;

  localparam int unsigned VALUE_BITS  = 16;
  localparam int unsigned FRAC_BITS   = 15;
  localparam int unsigned OUT_BITS    = FRAC_BITS + 1;
  localparam int unsigned MODE_BITS   = 2;

  // divider: quotient bits resolved per pipeline stage
  localparam int unsigned DIV_STEPS   = 3;
  localparam int unsigned DIV_STAGES  = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned QUO_BITS    = DIV_STAGES * DIV_STEPS;
  localparam int unsigned QUO_EXTRA   = QUO_BITS - FRAC_BITS;

  localparam int unsigned IN_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int unsigned REG_IDX_W   = 3;
  localparam int unsigned APB_ADDR_W  = REG_IDX_W + 2;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [REG_IDX_W-1:0] REG_SHAPE   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_BREAK_A = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_BREAK_B = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_BREAK_C = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_BREAK_D = REG_IDX_W'(4);

  // 1.0 in the output format
  localparam logic [OUT_BITS-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [MODE_BITS-1:0] {
    SHAPE_RISE = 2'd0,
    SHAPE_FALL = 2'd1,
    SHAPE_TRI  = 2'd2,
    SHAPE_TRAP = 2'd3
  } shape_e;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  localparam value_t BREAK_A_RST = VALUE_BITS'(0);
  localparam value_t BREAK_B_RST = VALUE_BITS'(8192);
  localparam value_t BREAK_C_RST = VALUE_BITS'(16384);
  localparam value_t BREAK_D_RST = VALUE_BITS'(24576);

  typedef struct packed {
    shape_e mode;
    value_t a;
    value_t b;
    value_t c;
    value_t d;
  } fme_cfg_t;

  // one item in flight: either a fixed degree or a ramp division in progress
  typedef struct packed {
    logic                  use_const;
    logic [OUT_BITS-1:0]   const_val;
    logic [VALUE_BITS-1:0] rem;
    logic [VALUE_BITS-1:0] den;
    logic [QUO_BITS-1:0]   quo;
  } fme_item_t;

endpackage

// ----- hw/rtl/fme_classify.sv -----
// breakpoint compare and segment select, sets up the ramp division
module fme_classify import fme_pkg::*; (
  input  value_t    sample_i,
  input  fme_cfg_t  cfg_i,
  output fme_item_t item_o
);

  logic signed [VALUE_BITS:0] v_x, a_x, b_x, c_x, d_x;
  logic [VALUE_BITS-1:0] va, bv, ba, cv, cb, dv, dc;
  logic le_a, ge_b, eq_b, ge_c, le_c, ge_d, lt_b;

  assign v_x = {sample_i[VALUE_BITS-1], sample_i};
  assign a_x = {cfg_i.a[VALUE_BITS-1], cfg_i.a};
  assign b_x = {cfg_i.b[VALUE_BITS-1], cfg_i.b};
  assign c_x = {cfg_i.c[VALUE_BITS-1], cfg_i.c};
  assign d_x = {cfg_i.d[VALUE_BITS-1], cfg_i.d};

  // segment lengths, only used where they are known positive and below 2^VALUE_BITS
  assign va = VALUE_BITS'($unsigned(v_x - a_x));
  assign bv = VALUE_BITS'($unsigned(b_x - v_x));
  assign ba = VALUE_BITS'($unsigned(b_x - a_x));
  assign cv = VALUE_BITS'($unsigned(c_x - v_x));
  assign cb = VALUE_BITS'($unsigned(c_x - b_x));
  assign dv = VALUE_BITS'($unsigned(d_x - v_x));
  assign dc = VALUE_BITS'($unsigned(d_x - c_x));

  assign le_a = sample_i <= cfg_i.a;
  assign ge_b = sample_i >= cfg_i.b;
  assign eq_b = sample_i == cfg_i.b;
  assign lt_b = !ge_b;
  assign ge_c = sample_i >= cfg_i.c;
  assign le_c = sample_i <= cfg_i.c;
  assign ge_d = sample_i >= cfg_i.d;

  always_comb begin
    item_o           = '0;
    item_o.use_const = 1'b1;
    unique case (cfg_i.mode)
      SHAPE_RISE: begin
        priority if (le_a) begin
          item_o.const_val = '0;
        end else if (ge_b) begin
          item_o.const_val = ONE_Q;
        end else begin
          item_o.use_const = 1'b0;
          item_o.rem       = va;
          item_o.den       = ba;
        end
      end
      SHAPE_FALL: begin
        priority if (le_a) begin
          item_o.const_val = ONE_Q;
        end else if (ge_b) begin
          item_o.const_val = '0;
        end else begin
          item_o.use_const = 1'b0;
          item_o.rem       = bv;
          item_o.den       = ba;
        end
      end
      SHAPE_TRI: begin
        priority if (le_a) begin
          item_o.const_val = '0;
        end else if (eq_b) begin
          item_o.const_val = ONE_Q;
        end else if (ge_c) begin
          item_o.const_val = '0;
        end else if (lt_b) begin
          item_o.use_const = 1'b0;
          item_o.rem       = va;
          item_o.den       = ba;
        end else begin
          item_o.use_const = 1'b0;
          item_o.rem       = cv;
          item_o.den       = cb;
        end
      end
      SHAPE_TRAP: begin
        priority if (le_a) begin
          item_o.const_val = '0;
        end else if (ge_b && le_c) begin
          item_o.const_val = ONE_Q;
        end else if (ge_d) begin
          item_o.const_val = '0;
        end else if (lt_b) begin
          item_o.use_const = 1'b0;
          item_o.rem       = va;
          item_o.den       = ba;
        end else begin
          item_o.use_const = 1'b0;
          item_o.rem       = dv;
          item_o.den       = dc;
        end
      end
      default: begin
        item_o.const_val = '0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/fme_div_stage.sv -----
// restoring divider slice, resolves DIV_STEPS quotient bits
module fme_div_stage import fme_pkg::*; (
  input  fme_item_t item_i,
  output fme_item_t item_o
);

  logic [VALUE_BITS-1:0] rem_s [DIV_STEPS+1];
  logic [QUO_BITS-1:0]   quo_s [DIV_STEPS+1];
  logic [VALUE_BITS:0]   sh_s  [DIV_STEPS];
  logic [DIV_STEPS-1:0]  take_s;

  assign rem_s[0] = item_i.rem;
  assign quo_s[0] = item_i.quo;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    assign sh_s[j]      = {rem_s[j], 1'b0};
    assign take_s[j]    = sh_s[j] >= {1'b0, item_i.den};
    assign rem_s[j+1]   = take_s[j] ? VALUE_BITS'(sh_s[j] - {1'b0, item_i.den})
                                    : sh_s[j][VALUE_BITS-1:0];
    assign quo_s[j+1]   = {quo_s[j][QUO_BITS-2:0], take_s[j]};
  end

  always_comb begin
    item_o     = item_i;
    item_o.rem = rem_s[DIV_STEPS];
    item_o.quo = quo_s[DIV_STEPS];
  end

endmodule

// ----- hw/rtl/fuzzy_membership_eval_unit.sv -----
// fuzzy membership evaluator top level: config registers and pipeline
// pipeline: classify register, DIV_STAGES divide registers, then output register ahead of m_axis_tvalid
// throughput: one sample per cycle while the output is not stalled; the divider resolves 3 quotient bits per stage
// back-pressure collapses bubbles stage by stage, so a stall drops or repeats nothing
// reset (rst_ni low, asynchronous): all valid bits cleared, registers to their defaults
// defaults: rising ramp, breakpoints 0, 8192, 16384, 24576
module fuzzy_membership_eval_unit import fme_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // sample stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample_value
  // membership stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] membership_degree
  // register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  shape_e mode_q;
  value_t break_a_q, break_b_q, break_c_q, break_d_q;
  logic   cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  fme_cfg_t cfg;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= SHAPE_RISE;
      break_a_q <= BREAK_A_RST;
      break_b_q <= BREAK_B_RST;
      break_c_q <= BREAK_C_RST;
      break_d_q <= BREAK_D_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SHAPE:   mode_q    <= shape_e'(pwdata[MODE_BITS-1:0]);
        REG_BREAK_A: break_a_q <= pwdata[VALUE_BITS-1:0];
        REG_BREAK_B: break_b_q <= pwdata[VALUE_BITS-1:0];
        REG_BREAK_C: break_c_q <= pwdata[VALUE_BITS-1:0];
        REG_BREAK_D: break_d_q <= pwdata[VALUE_BITS-1:0];
        default: ; // unmapped addresses ignore writes
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (reg_idx)
      REG_SHAPE:   prdata = APB_DATA_W'(mode_q);
      REG_BREAK_A: prdata = APB_DATA_W'($unsigned(break_a_q));
      REG_BREAK_B: prdata = APB_DATA_W'($unsigned(break_b_q));
      REG_BREAK_C: prdata = APB_DATA_W'($unsigned(break_c_q));
      REG_BREAK_D: prdata = APB_DATA_W'($unsigned(break_d_q));
      default:     prdata = '0;
    endcase
  end

  assign cfg.mode = mode_q;
  assign cfg.a    = break_a_q;
  assign cfg.b    = break_b_q;
  assign cfg.c    = break_c_q;
  assign cfg.d    = break_d_q;

  // ---------------------------------------------------------------------------
  // pipeline: stage 0 classify, stages 1..DIV_STAGES divide, then output reg
  // ---------------------------------------------------------------------------
  fme_item_t item_q   [DIV_STAGES+1];
  fme_item_t item_d   [DIV_STAGES+1];
  logic      vld_q    [DIV_STAGES+1];
  logic      stage_rdy[DIV_STAGES+1];

  logic [OUT_BITS-1:0] out_q, out_d;
  logic                out_vld_q;
  logic                out_rdy;
  fme_item_t           last;

  fme_classify u_classify (
    .sample_i (value_t'(s_axis_tdata[VALUE_BITS-1:0])),
    .cfg_i    (cfg),
    .item_o   (item_d[0])
  );

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    fme_div_stage u_div_stage (
      .item_i (item_q[k-1]),
      .item_o (item_d[k])
    );
  end

  // a stage may load when it is empty or its content moves on this cycle
  assign out_rdy = !out_vld_q || m_axis_tready;

  always_comb begin
    stage_rdy[DIV_STAGES] = !vld_q[DIV_STAGES] || out_rdy;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      stage_rdy[k] = !vld_q[k] || stage_rdy[k+1];
    end
  end

  assign s_axis_tready = stage_rdy[0];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else begin
      if (stage_rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
        if (stage_rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (out_rdy) begin
        out_vld_q <= vld_q[DIV_STAGES];
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= DIV_STAGES; k++) begin
      if (stage_rdy[k]) begin
        item_q[k] <= item_d[k];
      end
    end
    if (out_rdy) begin
      out_q <= out_d;
    end
  end

  // final select: fixed degree or truncated quotient
  assign last  = item_q[DIV_STAGES];
  assign out_d = last.use_const ? last.const_val : OUT_BITS'(last.quo >> QUO_EXTRA);

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_q);

endmodule

// ----- hw/rtl/fme_checker.sv -----
// port-level checker for the fuzzy membership evaluator, bound to the top level
`include "fuzzy_membership_eval_unit_assert.svh"

module fme_checker import fme_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   pready
);

  // degree never exceeds 1.0
  `FME_ASSERT_IMPLIES(a_degree_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata <= OUT_TDATA_W'(ONE_Q))

  // an output slot that is free or draining lets a new sample in
  `FME_ASSERT_IMPLIES(a_free_out_accepts, clk_i, rst_ni, !m_axis_tvalid || m_axis_tready, s_axis_tready)

  // a stalled result stays put
  `FME_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // register port never inserts wait states
  `FME_ASSERT_IMPLIES(a_pready_high, clk_i, rst_ni, 1'b1, pready)

endmodule

bind fuzzy_membership_eval_unit fme_checker u_fme_checker (.*);
